@@ src/msv_pkg.sv @@
package msv_pkg;

	localparam int POS_W = 11;

	typedef logic [POS_W-1:0] pos_val_t;

	typedef struct packed {
		pos_val_t nose;
		pos_val_t main;
		pos_val_t left;
		pos_val_t right;
		pos_val_t front;
	} pos_t;

	// handshake enables of the internal stages
	typedef struct packed {
		logic load_q;
		logic load_out;
	} map_ctl_t;

	typedef enum logic [1:0] {
		CFG_CAL_MODE = 2'd0,
		CFG_CAL_BANK = 2'd1
	} cfg_idx_t;

	localparam logic signed [12:0] CAL_BANK_RST = -13'sd640;

	localparam pos_val_t GEAR_DOWN_POS = 11'd100;
	localparam pos_val_t NOSE_UP_POS   = 11'd800;
	localparam pos_val_t MAIN_UP_POS   = 11'd1300;
	localparam pos_val_t MOTION_POS_MAX = 11'd2000;

	localparam logic [2:0] GEAR_STEP   = 3'd1;
	localparam logic [2:0] MOTION_STEP = 3'd4;

	localparam logic signed [11:0] NEUTRAL  = 12'sd50;
	localparam logic signed [11:0] GOAL_MAX = 12'sd100;
	localparam logic [6:0] GOAL_MAX_U = 7'd100;
	localparam logic [6:0] ANGLE_SPAN = 7'd110;

	// reciprocals: 3277 / 2^16 ~ 1/20, 205 / 2^11 ~ 1/10, exact over the used ranges
	localparam logic [11:0] RECIP20 = 12'd3277;
	localparam logic [7:0]  RECIP10 = 8'd205;

	// trunc(v * 3 / 32) toward zero
	function automatic logic signed [9:0] scale_3_32(input logic signed [12:0] v);
		logic signed [14:0] t;
		logic signed [14:0] a;
		t = $signed({{2{v[12]}}, v}) + $signed({v[12], v, 1'b0});
		a = t[14] ? t + 15'sd31 : t;
		return 10'(a >>> 5);
	endfunction

	function automatic logic [6:0] clamp_goal(input logic signed [11:0] v);
		logic [6:0] r;
		r = v[6:0];
		if (v < 12'sd0)
			r = '0;
		else if (v > GOAL_MAX)
			r = GOAL_MAX_U;
		return r;
	endfunction

	// goal times 20
	function automatic pos_val_t goal_to_pos(input logic [6:0] g);
		pos_val_t w;
		w = {4'b0, g};
		return (w << 4) + (w << 2);
	endfunction

	function automatic pos_val_t slew_step(input pos_val_t cur, input pos_val_t tgt,
			input logic [2:0] step);
		logic [POS_W:0] c;
		logic [POS_W:0] t;
		logic [POS_W:0] s;
		pos_val_t r;
		c = {1'b0, cur};
		t = {1'b0, tgt};
		s = {{(POS_W-2){1'b0}}, step};
		r = tgt;
		if (c > t + s)
			r = cur - {{(POS_W-3){1'b0}}, step};
		else if (t > c + s)
			r = cur + {{(POS_W-3){1'b0}}, step};
		return r;
	endfunction

endpackage

@@ src/msv_slew.sv @@
module msv_slew
	import msv_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic signed [12:0] pitch,
	input  logic signed [12:0] bank,
	input  logic               gear_down,
	input  logic               sim_enabled,
	input  logic               cal_mode,
	input  logic signed [12:0] cal_bank,
	output pos_t               pos
);

	pos_t pos_q;
	pos_t pos_n;
	logic gear_dn_q;
	logic [6:0] left_goal_q, right_goal_q, front_goal_q;

	logic upd;
	logic signed [12:0] p_eff, b_eff;
	logic signed [9:0] po, bo;
	logic gear_dn_n;
	logic [6:0] left_goal_n, right_goal_n, front_goal_n;
	pos_val_t nose_dest, main_dest;

	always_comb begin
		upd   = sim_enabled | cal_mode;
		p_eff = cal_mode ? 13'sd0 : pitch;
		b_eff = cal_mode ? cal_bank : bank;
		po    = scale_3_32(p_eff);
		bo    = scale_3_32(b_eff);

		gear_dn_n    = gear_dn_q;
		left_goal_n  = left_goal_q;
		right_goal_n = right_goal_q;
		front_goal_n = front_goal_q;
		if (upd) begin
			gear_dn_n    = gear_down;
			front_goal_n = clamp_goal(NEUTRAL + 12'(po));
			left_goal_n  = clamp_goal(NEUTRAL - 12'(po) + 12'(bo));
			right_goal_n = clamp_goal(NEUTRAL - 12'(po) - 12'(bo));
		end

		nose_dest = gear_dn_n ? GEAR_DOWN_POS : NOSE_UP_POS;
		main_dest = gear_dn_n ? GEAR_DOWN_POS : MAIN_UP_POS;

		pos_n.nose  = slew_step(pos_q.nose, nose_dest, GEAR_STEP);
		pos_n.main  = slew_step(pos_q.main, main_dest, GEAR_STEP);
		pos_n.left  = slew_step(pos_q.left, goal_to_pos(left_goal_n), MOTION_STEP);
		pos_n.right = slew_step(pos_q.right, goal_to_pos(right_goal_n), MOTION_STEP);
		pos_n.front = slew_step(pos_q.front, goal_to_pos(front_goal_n), MOTION_STEP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q.nose   <= GEAR_DOWN_POS;
			pos_q.main   <= GEAR_DOWN_POS;
			pos_q.left   <= '0;
			pos_q.right  <= '0;
			pos_q.front  <= '0;
			gear_dn_q    <= 1'b1;
			left_goal_q  <= '0;
			right_goal_q <= '0;
			front_goal_q <= '0;
		end else if (adv) begin
			pos_q        <= pos_n;
			gear_dn_q    <= gear_dn_n;
			left_goal_q  <= left_goal_n;
			right_goal_q <= right_goal_n;
			front_goal_q <= front_goal_n;
		end
	end

	assign pos = pos_q;

	a_goals_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		left_goal_q <= GOAL_MAX_U && right_goal_q <= GOAL_MAX_U && front_goal_q <= GOAL_MAX_U)
		else $error("motion goal beyond full travel");

	a_motion_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q.left <= MOTION_POS_MAX && pos_q.right <= MOTION_POS_MAX
		&& pos_q.front <= MOTION_POS_MAX)
		else $error("motion position beyond full travel");

	a_gear_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q.nose >= GEAR_DOWN_POS && pos_q.nose <= NOSE_UP_POS
		&& pos_q.main >= GEAR_DOWN_POS && pos_q.main <= MAIN_UP_POS)
		else $error("gear position outside its travel");

	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(pos_q))
		else $error("positions moved without a tick");

endmodule

@@ src/msv_angle.sv @@
module msv_angle
	import msv_pkg::*;
(
	input  logic       clk,
	input  map_ctl_t   ctl,
	input  pos_t       pos,
	output logic [5:0] nose_angle,
	output logic [6:0] main_angle,
	output logic [6:0] left_angle,
	output logic [6:0] right_angle,
	output logic [6:0] front_angle
);

	logic [6:0] nose_s3, main_s3, left_s3, right_s3, front_s3;
	logic [5:0] nose_s4;
	logic [6:0] main_s4, left_s4, right_s4, front_s4;

	function automatic logic [6:0] div20(input pos_val_t p);
		logic [22:0] m;
		m = {12'b0, p} * {11'b0, RECIP20};
		return m[22:16];
	endfunction

	// x * 110 / 100 as x + x / 10
	function automatic logic [6:0] span_map(input logic [6:0] x);
		logic [14:0] m;
		m = {8'b0, x} * {7'b0, RECIP10};
		return x + {3'b0, m[14:11]};
	endfunction

	always_ff @(posedge clk) begin
		if (ctl.load_q) begin
			nose_s3  <= div20(pos.nose);
			main_s3  <= div20(pos.main);
			left_s3  <= div20(pos.left);
			right_s3 <= div20(pos.right);
			front_s3 <= div20(pos.front);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			nose_s4  <= nose_s3[5:0];
			main_s4  <= main_s3;
			left_s4  <= ANGLE_SPAN - span_map(left_s3);
			right_s4 <= span_map(right_s3);
			front_s4 <= span_map(front_s3);
		end
	end

	assign nose_angle  = nose_s4;
	assign main_angle  = main_s4;
	assign left_angle  = left_s4;
	assign right_angle = right_s4;
	assign front_angle = front_s4;

endmodule

@@ src/motion_platform_servo_slew.sv @@
// channel   | handshake             | payload
// ----------+-----------------------+-------------------------------------------------
// tick in   | in_valid / in_stall   | pitch, bank, gear_down, sim_enabled
// angles out| out_valid / out_stall | nose_angle, main_angle, left/right/front_angle
// config    | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one tick per cycle sustained while out_stall is low; after the input transfer a tick passes
// the input register, position update, divide by 20 and angle mapping, then out_valid rises
// arst_n clears valid bits, calibration registers, positions and goals to their rest values
// a stage holds under out_stall once the stages after it are full; in_stall rises only once the input register is full
// cfg_ready is always high, indexes other than cal_mode and cal_bank are dropped
module motion_platform_servo_slew
	import msv_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [12:0] pitch,
	input  logic signed [12:0] bank,
	input  logic               gear_down,
	input  logic               sim_enabled,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [5:0]         nose_angle,
	output logic [6:0]         main_angle,
	output logic [6:0]         left_angle,
	output logic [6:0]         right_angle,
	output logic [6:0]         front_angle,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [12:0]        cfg_data
);

	logic               cal_mode_q;
	logic signed [12:0] cal_bank_q;

	logic               v_s1, v_s2, v_s3, v_out_q;
	logic signed [12:0] pitch_s1, bank_s1;
	logic               gear_down_s1, sim_enabled_s1;

	logic     ld_1, ld_2, ld_3, ld_o;
	pos_t     pos;
	map_ctl_t map_ctl;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_mode_q <= 1'b0;
			cal_bank_q <= CAL_BANK_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CAL_MODE: cal_mode_q <= cfg_data[0];
				CFG_CAL_BANK: cal_bank_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// stage enables, back to front
	always_comb begin
		ld_o     = v_s3 & (~v_out_q | ~out_stall);
		ld_3     = v_s2 & (~v_s3 | ld_o);
		ld_2     = v_s1 & (~v_s2 | ld_3);
		in_stall = v_s1 & ~ld_2;
		ld_1     = in_valid & ~in_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			v_s1    <= ld_1 | (v_s1 & ~ld_2);
			v_s2    <= ld_2 | (v_s2 & ~ld_3);
			v_s3    <= ld_3 | (v_s3 & ~ld_o);
			v_out_q <= ld_o | (v_out_q & out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (ld_1) begin
			pitch_s1       <= pitch;
			bank_s1        <= bank;
			gear_down_s1   <= gear_down;
			sim_enabled_s1 <= sim_enabled;
		end
	end

	msv_slew u_slew (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (ld_2),
		.pitch       (pitch_s1),
		.bank        (bank_s1),
		.gear_down   (gear_down_s1),
		.sim_enabled (sim_enabled_s1),
		.cal_mode    (cal_mode_q),
		.cal_bank    (cal_bank_q),
		.pos         (pos)
	);

	assign map_ctl.load_q   = ld_3;
	assign map_ctl.load_out = ld_o;

	msv_angle u_angle (
		.clk         (clk),
		.ctl         (map_ctl),
		.pos         (pos),
		.nose_angle  (nose_angle),
		.main_angle  (main_angle),
		.left_angle  (left_angle),
		.right_angle (right_angle),
		.front_angle (front_angle)
	);

	assign out_valid = v_out_q;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> !in_stall)
		else $error("input stalled with an empty input register");

	a_update_lands: assert property (@(posedge clk) disable iff (!arst_n)
		ld_2 |=> v_s2)
		else $error("position update lost its stage valid");

	a_stall_blocks_output: assert property (@(posedge clk) disable iff (!arst_n)
		v_out_q && out_stall |-> !ld_o)
		else $error("output register overwritten while stalled");

endmodule
